[src/olist_pkg.sv]
// Shared types and codes for the ordered list engine.
package olist_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned OPCODE_W  = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OUT_CNT_W = 5;

    // Operation codes
    typedef logic [OPCODE_W-1:0] t_op;
    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_INSERT     = 3'd4;
    localparam t_op OP_REMOVE     = 3'd5;
    localparam t_op OP_PEEK       = 3'd6;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;
    localparam t_status STAT_MISS  = 2'd3;

    // Move applied by every cell in the update cycle
    typedef enum logic [2:0] {
        MODE_HOLD        = 3'd0,
        MODE_OPEN_FRONT  = 3'd1,
        MODE_OPEN_BACK   = 3'd2,
        MODE_CLOSE_FRONT = 3'd3,
        MODE_OPEN_PAIR   = 3'd4,
        MODE_CLOSE_MATCH = 3'd5
    } t_mode;

    // Control broadcast from the sequencer to the row of cells
    typedef struct packed {
        logic              cmp_en;
        logic              scan_en;
        logic              pair;
        t_mode             mode;
        logic [DATA_W-1:0] item;
        logic [DATA_W-1:0] before_val;
        logic [DATA_W-1:0] after_val;
    } t_cell_ctl;

endpackage

[src/olist_cell.sv]
// One storage cell of the list row: holds an entry, its match flags and its shift logic.
module olist_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic                      i_clk,
    input  olist_pkg::t_cell_ctl      i_ctl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [olist_pkg::DATA_W-1:0] i_prev_val,
    input  logic [olist_pkg::DATA_W-1:0] i_next_val,
    input  logic [olist_pkg::DATA_W-1:0] i_head_val,
    input  logic                      i_prev_first,
    input  logic                      i_prev_ge,
    input  logic                      i_hit,
    output logic                      o_hit,
    output logic                      o_first,
    output logic                      o_ge,
    output logic [olist_pkg::DATA_W-1:0] o_val
);
    import olist_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic              r_pair_eq;
    logic              r_item_eq;
    logic              r_first;
    logic              r_ge;
    logic              w_in_list;
    logic              w_is_tail;
    logic              w_sel;
    logic [DATA_W-1:0] w_nbr;

    // Locate this cell against the fill level
    assign w_in_list = CNT_W'(IDX) < i_count;
    assign w_is_tail = CNT_W'(IDX + 1) == i_count;
    // The tail pairs with the head
    assign w_nbr     = w_is_tail ? i_head_val : i_next_val;

    // Carry the match chain to the neighbor
    assign w_sel = i_ctl.pair ? r_pair_eq : r_item_eq;
    assign o_hit = i_hit | w_sel;

    // Compare and scan flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_pair_eq <= w_in_list && (r_val == i_ctl.before_val) && (w_nbr == i_ctl.after_val);
            r_item_eq <= w_in_list && (r_val == i_ctl.item);
        end
        if (i_ctl.scan_en) begin
            r_first <= w_sel & ~i_hit;
            r_ge    <= w_sel | i_hit;
        end
    end

    // Pick the next entry value
    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            MODE_OPEN_FRONT:  n_val = (IDX == 0) ? i_ctl.item : i_prev_val;
            MODE_OPEN_BACK:   n_val = (CNT_W'(IDX) == i_count) ? i_ctl.item : r_val;
            MODE_CLOSE_FRONT: n_val = i_next_val;
            MODE_OPEN_PAIR: begin
                if (i_prev_first) begin
                    n_val = i_ctl.item;
                end else if (i_prev_ge) begin
                    n_val = i_prev_val;
                end
            end
            MODE_CLOSE_MATCH: n_val = r_ge ? i_next_val : r_val;
            default:          n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_first = r_first;
    assign o_ge    = r_ge;
    assign o_val   = r_val;

endmodule

[src/ordered_list_engine.sv]
// Top level of the ordered list engine: sequencer, row of cells and result register.
//
//   channel   | dir | handshake                    | content
//   s_axis    | in  | s_axis_tvalid/s_axis_tready  | operation item (opcode in tuser)
//   m_axis    | out | m_axis_tvalid/m_axis_tready  | result item: status, value, count
//
// An item passes through accept, compare in every cell, scan the match chain
// across the row and update every cell at once. The match chain through
// the row of cells sets the scan cycle.
// Reset clears the fill count, the sequencer and the output valid flag; entries
// are not cleared and are only read below the fill count.
// The update waits while the previous result is still held on m_axis; a new
// item is accepted as soon as the sequencer is back in idle.
module ordered_list_engine #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits [31:0] item_value, [63:32] before_value, [95:64] after_value,
    // [99:96] position, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    // bits [2:0] opcode
    input  olist_pkg::t_op s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits [1:0] status, [33:2] out_value, [38:34] entry_count, [39] zero
    output logic [39:0]  m_axis_tdata
);
    import olist_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        SEQ_IDLE  = 4'b0001,
        SEQ_CMP   = 4'b0010,
        SEQ_SCAN  = 4'b0100,
        SEQ_APPLY = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_op                r_op;
    logic [DATA_W-1:0]  r_item;
    logic [DATA_W-1:0]  r_before;
    logic [DATA_W-1:0]  r_after;
    logic [POS_W-1:0]   r_pos;
    logic [DATA_W-1:0]  r_rd;
    logic               r_out_valid;
    t_status            r_status;
    logic [DATA_W-1:0]  r_value;
    logic [OUT_CNT_W-1:0] r_out_count;

    t_cell_ctl          w_ctl;
    t_mode              w_mode;
    t_status            w_status;
    logic [DATA_W-1:0]  w_value;
    logic               w_accept;
    logic               w_fire;
    logic               w_empty;
    logic               w_full;
    logic               w_any;
    logic               w_wrap;
    logic               w_pos_ok;
    logic [CNT_W-1:0]   w_last;
    logic [IDX_W-1:0]   w_tail_idx;
    logic [IDX_W-1:0]   w_rd_idx;
    logic [IDX_W+POS_W-1:0] w_pos_wide;
    logic [CNT_W+POS_W-1:0] w_pos_cmp;
    logic [CNT_W+POS_W-1:0] w_cnt_cmp;
    logic [CNT_W+OUT_CNT_W-1:0] w_cnt_out;

    logic [DATA_W-1:0]  w_vals      [CAPACITY];
    logic [DATA_W-1:0]  w_prev_val  [CAPACITY];
    logic [DATA_W-1:0]  w_next_val  [CAPACITY];
    logic               w_prev_first[CAPACITY];
    logic               w_prev_ge   [CAPACITY];
    logic               w_first     [CAPACITY];
    logic               w_ge        [CAPACITY];
    logic               w_hit       [CAPACITY+1];

    assign s_axis_tready = (r_state == SEQ_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_state == SEQ_APPLY) && (!r_out_valid || m_axis_tready);

    // Decode fill level and read addresses
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_last     = r_count - CNT_W'(1);
    assign w_tail_idx = w_last[IDX_W-1:0];
    assign w_pos_wide = {{IDX_W{1'b0}}, r_pos};
    assign w_pos_cmp  = {{CNT_W{1'b0}}, r_pos};
    assign w_cnt_cmp  = {{POS_W{1'b0}}, r_count};
    assign w_pos_ok   = w_pos_cmp < w_cnt_cmp;
    assign w_any      = w_ge[CAPACITY-1];
    assign w_wrap     = w_first[w_tail_idx];

    always_comb begin
        case (r_op)
            OP_POP_BACK: w_rd_idx = w_tail_idx;
            OP_PEEK:     w_rd_idx = w_pos_wide[IDX_W-1:0];
            default:     w_rd_idx = '0;
        endcase
    end

    // Broadcast control to the row
    assign w_ctl.cmp_en     = (r_state == SEQ_CMP);
    assign w_ctl.scan_en    = (r_state == SEQ_SCAN);
    assign w_ctl.pair       = (r_op == OP_INSERT);
    assign w_ctl.mode       = w_fire ? w_mode : MODE_HOLD;
    assign w_ctl.item       = r_item;
    assign w_ctl.before_val = r_before;
    assign w_ctl.after_val  = r_after;

    // Row of cells with neighbor links
    assign w_hit[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_val[g]   = w_vals[g];
            assign w_prev_first[g] = 1'b0;
            assign w_prev_ge[g]    = 1'b0;
        end else begin : g_body
            assign w_prev_val[g]   = w_vals[g-1];
            assign w_prev_first[g] = w_first[g-1];
            assign w_prev_ge[g]    = w_ge[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_next_val[g] = w_vals[g];
        end else begin : g_mid
            assign w_next_val[g] = w_vals[g+1];
        end

        olist_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_prev_val   (w_prev_val[g]),
            .i_next_val   (w_next_val[g]),
            .i_head_val   (w_vals[0]),
            .i_prev_first (w_prev_first[g]),
            .i_prev_ge    (w_prev_ge[g]),
            .i_hit        (w_hit[g]),
            .o_hit        (w_hit[g+1]),
            .o_first      (w_first[g]),
            .o_ge         (w_ge[g]),
            .o_val        (w_vals[g])
        );
    end

    // Work out the move, status and new count
    always_comb begin
        w_mode   = MODE_HOLD;
        w_status = STAT_OK;
        w_value  = '0;
        n_count  = r_count;
        case (r_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_mode  = (r_op == OP_PUSH_FRONT) ? MODE_OPEN_FRONT : MODE_OPEN_BACK;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else begin
                    w_mode  = (r_op == OP_POP_FRONT) ? MODE_CLOSE_FRONT : MODE_HOLD;
                    w_value = r_rd;
                    n_count = w_last;
                end
            end
            OP_INSERT: begin
                if (w_empty) begin
                    w_mode  = MODE_OPEN_FRONT;
                    n_count = r_count + CNT_W'(1);
                end else if (w_full) begin
                    w_status = STAT_FULL;
                end else if (w_any) begin
                    w_mode  = w_wrap ? MODE_OPEN_FRONT : MODE_OPEN_PAIR;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    w_status = STAT_MISS;
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else if (w_any) begin
                    w_mode  = MODE_CLOSE_MATCH;
                    w_value = r_item;
                    n_count = w_last;
                end else begin
                    w_status = STAT_MISS;
                end
            end
            OP_PEEK: begin
                if (w_pos_ok) begin
                    w_value = r_rd;
                end else begin
                    w_status = STAT_EMPTY;
                end
            end
            default: begin
                w_mode = MODE_HOLD;
            end
        endcase
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE:  n_state = w_accept ? SEQ_CMP : SEQ_IDLE;
            SEQ_CMP:   n_state = SEQ_SCAN;
            SEQ_SCAN:  n_state = SEQ_APPLY;
            SEQ_APPLY: n_state = w_fire ? SEQ_IDLE : SEQ_APPLY;
            default:   n_state = SEQ_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_cnt_out = {{OUT_CNT_W{1'b0}}, n_count};

    // Capture the item, the read word and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= s_axis_tuser;
            r_item   <= s_axis_tdata[31:0];
            r_before <= s_axis_tdata[63:32];
            r_after  <= s_axis_tdata[95:64];
            r_pos    <= s_axis_tdata[99:96];
        end
        if (r_state == SEQ_CMP) begin
            r_rd <= w_vals[w_rd_idx];
        end
        if (w_fire) begin
            r_status    <= w_status;
            r_value     <= w_value;
            r_out_count <= w_cnt_out[OUT_CNT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count, r_value, r_status};

endmodule
